// ===== hdl/egcd_pkg.sv =====
// Package with shared constants, microcode types and the control store for the extended GCD block.
package egcd_pkg;

    localparam int OPERAND_WIDTH_DEFAULT = 32;
    localparam int PC_WIDTH = 3;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_INIT,
        ACT_STEP,
        ACT_UPDATE,
        ACT_EMIT
    } act_t;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_IF_NO_INPUT,
        JMP_IF_Y_ZERO,
        JMP_IF_COUNT_NZ,
        JMP_IF_OUT_BUSY
    } jmp_t;

    typedef logic [PC_WIDTH-1:0] pc_t;

    localparam pc_t PC_FETCH  = 3'd0;
    localparam pc_t PC_TEST   = 3'd1;
    localparam pc_t PC_INIT   = 3'd2;
    localparam pc_t PC_STEP   = 3'd3;
    localparam pc_t PC_UPDATE = 3'd4;
    localparam pc_t PC_EMIT   = 3'd5;

    typedef struct packed {
        act_t act;
        jmp_t jmp;
        pc_t  target;
    } ucode_t;

    typedef struct packed {
        act_t act;
        logic in_ready;
    } egcd_ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic y_zero;
        logic out_busy;
    } egcd_stat_t;

    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t word;
        case (pc)
            PC_FETCH:  word = '{act: ACT_LOAD,   jmp: JMP_IF_NO_INPUT, target: PC_FETCH};
            PC_TEST:   word = '{act: ACT_NONE,   jmp: JMP_IF_Y_ZERO,   target: PC_EMIT};
            PC_INIT:   word = '{act: ACT_INIT,   jmp: JMP_NEXT,        target: PC_FETCH};
            PC_STEP:   word = '{act: ACT_STEP,   jmp: JMP_IF_COUNT_NZ, target: PC_STEP};
            PC_UPDATE: word = '{act: ACT_UPDATE, jmp: JMP_ALWAYS,      target: PC_TEST};
            PC_EMIT:   word = '{act: ACT_EMIT,   jmp: JMP_IF_OUT_BUSY, target: PC_EMIT};
            default:   word = '{act: ACT_NONE,   jmp: JMP_ALWAYS,      target: PC_FETCH};
        endcase
        return word;
    endfunction

endpackage

// ===== hdl/egcd_in_if.sv =====
// Input channel interface carrying the two operands.
interface egcd_in_if #(
    parameter int OPERAND_WIDTH = 32
);
    logic                     valid;
    logic                     ready;
    logic [OPERAND_WIDTH-1:0] operand_a;
    logic [OPERAND_WIDTH-1:0] operand_b;

    modport source (output valid, output operand_a, output operand_b, input ready);
    modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

// ===== hdl/egcd_out_if.sv =====
// Output channel interface carrying the GCD and the two Bezout coefficients.
interface egcd_out_if #(
    parameter int OPERAND_WIDTH = 32
);
    logic                            valid;
    logic                            ready;
    logic        [OPERAND_WIDTH-1:0] gcd_value;
    logic signed [OPERAND_WIDTH:0]   coeff_a;
    logic signed [OPERAND_WIDTH:0]   coeff_b;

    modport source (output valid, output gcd_value, output coeff_a, output coeff_b, input ready);
    modport sink   (input valid, input gcd_value, input coeff_a, input coeff_b, output ready);
endinterface

// ===== hdl/extended_gcd.sv =====
// Top level of the extended GCD block: datapath, output register and the microcode sequencer.
//
//   channel   direction   payload                              transaction
//   in_ch     sink        operand_a, operand_b                 valid && ready
//   out_ch    source      gcd_value, coeff_a, coeff_b          valid && ready
//
// Each Euclid step consists of a zero test, a setup step, one
// restoring-division cycle per quotient bit, and a coefficient update. The quotient
// times the next coefficient is accumulated from the quotient bits as they appear.
// Besides the steps, an item passes from acceptance until input is ready again through
// the load, the final zero test, the emit and a return step. The emit step waits while
// the output register holds an unaccepted result. Reset clears the sequencer and the
// output valid flag.
module extended_gcd
    import egcd_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
)(
    input  logic              clk,
    input  logic              rst_n,
    egcd_in_if.sink           in_ch,
    egcd_out_if.source        out_ch
);

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = OPERAND_WIDTH + 1;

    egcd_ctrl_t ctrl;
    egcd_stat_t stat;

    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  y_reg, y_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [CW-1:0] ca_reg, ca_next;
    logic [CW-1:0] ca1_reg, ca1_next;
    logic [CW-1:0] cb_reg, cb_next;
    logic [CW-1:0] cb1_reg, cb1_next;
    logic [CW-1:0] acc_a_reg, acc_a_next;
    logic [CW-1:0] acc_b_reg, acc_b_next;

    logic          out_valid_reg, out_valid_next;
    logic [W-1:0]  out_gcd_reg, out_gcd_next;
    logic [CW-1:0] out_ca_reg, out_ca_next;
    logic [CW-1:0] out_cb_reg, out_cb_next;

    logic [W:0]    rem_shift;
    logic [W:0]    rem_diff;
    logic          qbit;

    egcd_seq #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_seq (
        .clk  (clk),
        .rst_n(rst_n),
        .stat (stat),
        .ctrl (ctrl)
    );

    assign stat.in_valid = in_ch.valid;
    assign stat.y_zero   = (y_reg == '0);
    assign stat.out_busy = out_valid_reg && !out_ch.ready;

    assign rem_shift = {rem_reg, x_reg[W-1]};
    assign rem_diff  = rem_shift - {1'b0, y_reg};
    assign qbit      = !rem_diff[W];

    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        rem_next   = rem_reg;
        ca_next    = ca_reg;
        ca1_next   = ca1_reg;
        cb_next    = cb_reg;
        cb1_next   = cb1_reg;
        acc_a_next = acc_a_reg;
        acc_b_next = acc_b_reg;
        case (ctrl.act)
            ACT_LOAD:
            begin
                x_next   = in_ch.operand_a;
                y_next   = in_ch.operand_b;
                ca_next  = CW'(1);
                ca1_next = '0;
                cb_next  = '0;
                cb1_next = CW'(1);
            end
            ACT_INIT:
            begin
                rem_next   = '0;
                acc_a_next = '0;
                acc_b_next = '0;
            end
            ACT_STEP:
            begin
                rem_next   = qbit ? rem_diff[W-1:0] : rem_shift[W-1:0];
                x_next     = {x_reg[W-2:0], qbit};
                acc_a_next = {acc_a_reg[CW-2:0], 1'b0} + (qbit ? ca1_reg : '0);
                acc_b_next = {acc_b_reg[CW-2:0], 1'b0} + (qbit ? cb1_reg : '0);
            end
            ACT_UPDATE:
            begin
                x_next   = y_reg;
                y_next   = rem_reg;
                ca_next  = ca1_reg;
                ca1_next = ca_reg - acc_a_reg;
                cb_next  = cb1_reg;
                cb1_next = cb_reg - acc_b_reg;
            end
            default:
            begin
                x_next = x_reg;
            end
        endcase
    end

    always_comb
    begin
        out_gcd_next   = out_gcd_reg;
        out_ca_next    = out_ca_reg;
        out_cb_next    = out_cb_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        if (ctrl.act == ACT_EMIT)
        begin
            out_valid_next = 1'b1;
            out_gcd_next   = x_reg;
            out_ca_next    = ca_reg;
            out_cb_next    = cb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        rem_reg     <= rem_next;
        ca_reg      <= ca_next;
        ca1_reg     <= ca1_next;
        cb_reg      <= cb_next;
        cb1_reg     <= cb1_next;
        acc_a_reg   <= acc_a_next;
        acc_b_reg   <= acc_b_next;
        out_gcd_reg <= out_gcd_next;
        out_ca_reg  <= out_ca_next;
        out_cb_reg  <= out_cb_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ch.ready      = ctrl.in_ready;
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.gcd_value = out_gcd_reg;
    assign out_ch.coeff_a   = $signed(out_ca_reg);
    assign out_ch.coeff_b   = $signed(out_cb_reg);

endmodule

// ===== hdl/egcd_seq.sv =====
// Microcode sequencer: program counter, control store lookup, jump logic and iteration counter.
module egcd_seq
    import egcd_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
)(
    input  logic       clk,
    input  logic       rst_n,
    input  egcd_stat_t stat,
    output egcd_ctrl_t ctrl
);

    localparam int CNT_WIDTH = $clog2(OPERAND_WIDTH);
    localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(OPERAND_WIDTH - 1);

    pc_t                  pc_reg;
    pc_t                  pc_next;
    logic [CNT_WIDTH-1:0] cnt_reg;
    logic [CNT_WIDTH-1:0] cnt_next;
    ucode_t               word;
    logic                 jump;
    logic                 wait_cond;
    act_t                 act;

    assign word = ucode_rom(pc_reg);

    always_comb
    begin
        jump      = 1'b0;
        wait_cond = 1'b0;
        case (word.jmp)
            JMP_NEXT:        jump = 1'b0;
            JMP_ALWAYS:      jump = 1'b1;
            JMP_IF_NO_INPUT:
            begin
                jump      = !stat.in_valid;
                wait_cond = 1'b1;
            end
            JMP_IF_Y_ZERO:   jump = stat.y_zero;
            JMP_IF_COUNT_NZ: jump = (cnt_reg != '0);
            JMP_IF_OUT_BUSY:
            begin
                jump      = stat.out_busy;
                wait_cond = 1'b1;
            end
            default:         jump = 1'b1;
        endcase
    end

    // A wait step performs its action only on the cycle it moves on.
    assign act = (wait_cond && jump) ? ACT_NONE : word.act;

    always_comb
    begin
        pc_next  = jump ? word.target : pc_t'(pc_reg + 1'b1);
        cnt_next = cnt_reg;
        case (act)
            ACT_INIT: cnt_next = CNT_LAST;
            ACT_STEP: cnt_next = cnt_reg - 1'b1;
            default:  cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= PC_FETCH;
            cnt_reg <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign ctrl.act      = act;
    assign ctrl.in_ready = (word.act == ACT_LOAD);

endmodule
